// ===== src/cdr_pkg.sv =====
// Package: shared types and constants for the CAN datagram reassembler.
`timescale 1ns / 1ps
package cdr_pkg;
  localparam int OpenEntries   = 4;
  localparam int DatagramBytes = 72;
  localparam int EntW  = (OpenEntries > 1) ? $clog2(OpenEntries) : 1;
  localparam int LenW  = $clog2(DatagramBytes + 1);
  localparam int ByteW = $clog2(DatagramBytes);
  localparam int MemD  = OpenEntries * DatagramBytes;
  localparam int MemW  = $clog2(MemD);

  localparam logic [2:0] TypeSingle = 3'd2;
  localparam logic [2:0] TypeFirst  = 3'd3;
  localparam logic [2:0] TypeMiddle = 3'd4;
  localparam logic [2:0] TypeFinal  = 3'd5;

  localparam logic [1:0] KindChunk      = 2'd0;
  localparam logic [1:0] KindOutOfOrder = 2'd1;
  localparam logic [1:0] KindTooLong    = 2'd2;

  typedef struct packed {
    logic [2:0]  ftype;
    logic [23:0] key;
    logic [3:0]  len;
    logic [63:0] bytes;
  } cmd_t;
endpackage

// ===== src/cdr_front.sv =====
// Front end: filters frames, clamps length, masks bytes, queues commands.
`timescale 1ns / 1ps
module cdr_front import cdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [28:0] frame_id_i,
  input  logic [3:0]  frame_length_i,
  input  logic [63:0] frame_bytes_i,
  input  logic        dest_is_local_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);
  // two-entry queue
  cmd_t       q_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  cmd_t       c;
  logic       keep, push;

  always_comb begin
    c.ftype = frame_id_i[26:24];
    c.key   = frame_id_i[23:0];
    c.len   = (frame_length_i > 4'd8) ? 4'd8 : frame_length_i;
    for (int i = 0; i < 8; i++)
      c.bytes[8*i +: 8] = (4'(i) < c.len) ? frame_bytes_i[8*i +: 8] : 8'h00;
    keep = dest_is_local_i && (c.ftype >= TypeSingle) && (c.ftype <= TypeFinal);
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule

// ===== src/cdr_back.sv =====
// Back end: entry table, byte store and chunk emission.
`timescale 1ns / 1ps
module cdr_back import cdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [11:0] source_alias_o,
  output logic [11:0] dest_alias_o,
  output logic [63:0] chunk_bytes_o,
  output logic [3:0]  chunk_count_o,
  output logic        last_chunk_o
);
  typedef enum logic [2:0] {S_IDLE, S_WRITE, S_READ, S_WAIT, S_EMIT} state_e;

  state_e            state_q;
  logic [OpenEntries-1:0] valid_q;
  logic [23:0]       key_q [OpenEntries];
  logic [LenW-1:0]   elen_q [OpenEntries];
  logic [7:0]        mem_q [MemD];
  logic [7:0]        rdata_q;
  cmd_t              cmd_q;
  logic [EntW-1:0]   ent_q;
  logic [3:0]        bi_q;     // byte index within frame/chunk
  logic [LenW-1:0]   base_q;   // write base or chunk base
  logic [LenW-1:0]   total_q;
  logic [63:0]       acc_q;
  logic [3:0]        ccnt_q;

  logic              hit, freef;
  logic [EntW-1:0]   hit_i, free_i;
  logic [LenW:0]     sum;
  logic [LenW:0]     rem;
  logic [3:0]        ccnt;
  logic [MemW-1:0]   waddr, raddr;

  always_comb begin
    hit = 1'b0; hit_i = '0; freef = 1'b0; free_i = '0;
    for (int i = OpenEntries - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == cmd_i.key) begin hit = 1'b1; hit_i = EntW'(i); end
      if (!valid_q[i]) begin freef = 1'b1; free_i = EntW'(i); end
    end
    sum   = (LenW+1)'(elen_q[hit_i]) + (LenW+1)'(cmd_i.len);
    rem   = (LenW+1)'(total_q) - (LenW+1)'(base_q);
    ccnt  = (rem > (LenW+1)'(8)) ? 4'd8 : rem[3:0];
    waddr = MemW'(ent_q) * MemW'(DatagramBytes) + MemW'(base_q) + MemW'(bi_q);
    raddr = waddr;
  end

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE && bi_q < cmd_q.len)
      mem_q[waddr] <= cmd_q.bytes[8*bi_q[2:0] +: 8];
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_q <= '0; result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          cmd_q <= cmd_i; bi_q <= 4'd0;
          result_kind_o  <= KindOutOfOrder;
          source_alias_o <= cmd_i.key[11:0];
          dest_alias_o   <= cmd_i.key[23:12];
          chunk_bytes_o  <= '0; chunk_count_o <= 4'd0; last_chunk_o <= 1'b1;
          unique case (cmd_i.ftype)
            TypeSingle: begin
              result_valid_o <= 1'b1; result_kind_o <= KindChunk;
              chunk_bytes_o <= cmd_i.bytes; chunk_count_o <= cmd_i.len;
            end
            TypeFirst: begin
              if (hit) begin
                valid_q[hit_i] <= 1'b0; result_valid_o <= 1'b1;
              end else if (!freef) begin
                result_valid_o <= 1'b1;
              end else begin
                valid_q[free_i] <= 1'b1; key_q[free_i] <= cmd_i.key;
                elen_q[free_i] <= LenW'(cmd_i.len);
                ent_q <= free_i; base_q <= '0; state_q <= S_WRITE;
              end
            end
            default: begin
              if (!hit) begin
                result_valid_o <= 1'b1;
              end else begin
                if (cmd_i.ftype == TypeFinal) valid_q[hit_i] <= 1'b0;
                if (sum > (LenW+1)'(DatagramBytes)) begin
                  result_valid_o <= 1'b1; result_kind_o <= KindTooLong;
                end else begin
                  elen_q[hit_i] <= LenW'(sum);
                  ent_q <= hit_i; base_q <= elen_q[hit_i];
                  total_q <= LenW'(sum);
                  state_q <= S_WRITE;
                end
              end
            end
          endcase
        end
        S_WRITE: begin
          if (bi_q >= cmd_q.len) begin
            if (cmd_q.ftype == TypeFinal) begin
              base_q <= '0; bi_q <= 4'd0; acc_q <= '0; state_q <= S_READ;
            end else state_q <= S_IDLE;
          end else bi_q <= bi_q + 4'd1;
        end
        S_READ: begin
          ccnt_q <= ccnt;
          if (bi_q >= ccnt) state_q <= S_EMIT;
          else state_q <= S_WAIT;
        end
        S_WAIT: begin
          acc_q[8*bi_q[2:0] +: 8] <= rdata_q;
          bi_q <= bi_q + 4'd1;
          state_q <= S_READ;
        end
        S_EMIT: begin
          result_valid_o <= 1'b1; result_kind_o <= KindChunk;
          chunk_bytes_o <= acc_q; chunk_count_o <= ccnt_q;
          if ((LenW+1)'(base_q) + (LenW+1)'(8) >= (LenW+1)'(total_q)) begin
            last_chunk_o <= 1'b1; state_q <= S_IDLE;
          end else begin
            last_chunk_o <= 1'b0;
            base_q <= base_q + LenW'(8); bi_q <= 4'd0; acc_q <= '0;
            state_q <= S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/can_datagram_reassembler.sv =====
// Top level: CAN datagram reassembler, front queue plus table back end.
// Single frames and rejections are reported by the back end when it pops their
// command from the front queue. A final frame holds the back end while its bytes
// are stored, then while they are read back and emitted in chunks of up to 8 bytes.
// First and middle frames hold the back end while their bytes are stored; the
// front queues two items, then raises busy. Reset clears the entry table at once.
`timescale 1ns / 1ps
module can_datagram_reassembler import cdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [28:0] frame_id_i,
  input  logic [3:0]  frame_length_i,
  input  logic [63:0] frame_bytes_i,
  input  logic        dest_is_local_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [11:0] source_alias_o,
  output logic [11:0] dest_alias_o,
  output logic [63:0] chunk_bytes_o,
  output logic [3:0]  chunk_count_o,
  output logic        last_chunk_o
);
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  cdr_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .frame_id_i, .frame_length_i, .frame_bytes_i, .dest_is_local_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  cdr_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .result_valid_o, .result_kind_o, .source_alias_o, .dest_alias_o,
    .chunk_bytes_o, .chunk_count_o, .last_chunk_o
  );
endmodule
